// ----- hw/rtl/text_console_writer_top_macros.svh -----
`ifndef TEXT_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_WRITER_TOP_MACROS_SVH

// Assertion helpers. Each expects aclk and aresetn in scope.

// The condition holds at every clock edge outside reset.
`define TCW_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define TCW_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/tcw_pkg.sv -----
`default_nettype none

package tcw_pkg;

    // Screen geometry.
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int CELL_AW = $clog2(CELLS);
    localparam int CUR_W   = $clog2(CELLS + 1);
    localparam int COL_W   = $clog2(COLUMNS);

    // Field widths.
    localparam int KIND_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int CELL_W   = CHAR_W + ATTR_W;

    // Character and attribute codes.
    localparam logic [CHAR_W-1:0] CHAR_NUL        = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE  = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_PRINT_LAST = 8'h7F;
    localparam logic [ATTR_W-1:0] ATTR_RESET      = 8'h17;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUT     = 2'd0,
        KIND_CLEAR   = 2'd1,
        KIND_READ    = 2'd2,
        KIND_RECOLOR = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_BS_READ,
        ST_BS_WRITE,
        ST_SCRL_READ,
        ST_SCRL_WRITE,
        ST_FILL,
        ST_RCLR_READ,
        ST_RCLR_WRITE,
        ST_CELL_READ,
        ST_CELL_TAKE,
        ST_DONE
    } state_t;

    typedef struct packed {
        kind_t               kind;
        logic [CHAR_W-1:0]   char_code;
        logic [INDEX_W-1:0]  cell_index;
    } cmd_t;

    typedef struct packed {
        logic                we;
        logic [CELL_AW-1:0]  waddr;
        logic [CELL_W-1:0]   wdata;
        logic [CELL_AW-1:0]  raddr;
    } mem_req_t;

    typedef struct packed {
        logic                idle;
        logic                done;
        logic [INDEX_W-1:0]  cursor_cell;
        logic [CHAR_W-1:0]   cell_char;
        logic [ATTR_W-1:0]   cell_attr;
    } seq_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tcw_cell_ram.sv -----
`default_nettype none

module tcw_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tcw_seq.sv -----
`default_nettype none

`include "text_console_writer_top_macros.svh"

module tcw_seq (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire tcw_pkg::cmd_t                 cmd,
    input  wire logic [tcw_pkg::ATTR_W-1:0]    attr,
    input  wire logic                          out_free,
    input  wire logic [tcw_pkg::CELL_W-1:0]    mem_rdata,
    output tcw_pkg::mem_req_t                  mem_req,
    output tcw_pkg::seq_status_t               status
);

    import tcw_pkg::*;

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [CELL_AW-1:0]   ptr_reg, ptr_next;
    logic [CUR_W-1:0]     cursor_reg, cursor_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [CHAR_W-1:0]    rd_char_reg, rd_char_next;
    logic [ATTR_W-1:0]    rd_attr_reg, rd_attr_next;

    // Shared sweep unit: pointer step, end tests and the row-below address.
    logic [CELL_AW-1:0]   ptr_inc;
    logic [CELL_AW-1:0]   ptr_below;
    logic                 ptr_is_last;
    logic                 ptr_is_scroll_last;

    // Cursor arithmetic for the put cases and the read range test.
    logic [CUR_W-1:0]     cur_newline;
    logic [CUR_W-1:0]     cur_inc;
    logic [COL_W-1:0]     col_inc;
    logic [COL_W-1:0]     col_dec;
    logic                 is_printable;
    logic                 read_in_range;

    assign ptr_inc            = ptr_reg + CELL_AW'(1);
    assign ptr_below          = ptr_reg + CELL_AW'(COLUMNS);
    assign ptr_is_last        = (ptr_reg == CELL_AW'(CELLS - 1));
    assign ptr_is_scroll_last = (ptr_reg == CELL_AW'(CELLS - COLUMNS - 1));

    assign cur_newline  = cursor_reg + (CUR_W'(COLUMNS) - CUR_W'(col_reg));
    assign cur_inc      = cursor_reg + CUR_W'(1);
    assign col_inc      = (col_reg == COL_W'(COLUMNS - 1)) ? '0 : col_reg + COL_W'(1);
    assign col_dec      = (col_reg == '0) ? COL_W'(COLUMNS - 1) : col_reg - COL_W'(1);
    assign is_printable = (cmd_reg.char_code inside {[CHAR_SPACE:CHAR_PRINT_LAST]});
    assign read_in_range = (32'(cmd_reg.cell_index) < 32'(CELLS));

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (cmd_reg.kind)
                    KIND_PUT: begin
                        if (cmd_reg.char_code == CHAR_NEWLINE) begin
                            state_next = (cur_newline == CUR_W'(CELLS)) ? ST_SCRL_READ : ST_DONE;
                        end else if (cmd_reg.char_code == CHAR_BACKSPACE) begin
                            state_next = ST_BS_READ;
                        end else if (is_printable) begin
                            state_next = (cur_inc == CUR_W'(CELLS)) ? ST_SCRL_READ : ST_DONE;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                    KIND_CLEAR:   state_next = ST_FILL;
                    KIND_READ:    state_next = read_in_range ? ST_CELL_READ : ST_DONE;
                    KIND_RECOLOR: state_next = ST_RCLR_READ;
                    default:      state_next = ST_DONE;
                endcase
            end
            ST_BS_READ:    state_next = ST_BS_WRITE;
            ST_BS_WRITE:   state_next = ST_DONE;
            ST_SCRL_READ:  state_next = ST_SCRL_WRITE;
            ST_SCRL_WRITE: state_next = ptr_is_scroll_last ? ST_FILL : ST_SCRL_READ;
            ST_FILL:       state_next = ptr_is_last ? ST_DONE : ST_FILL;
            ST_RCLR_READ:  state_next = ST_RCLR_WRITE;
            ST_RCLR_WRITE: state_next = ptr_is_last ? ST_DONE : ST_RCLR_READ;
            ST_CELL_READ:  state_next = ST_CELL_TAKE;
            ST_CELL_TAKE:  state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // Store requests.
    always_comb begin
        mem_req.we    = 1'b0;
        mem_req.waddr = ptr_reg;
        mem_req.wdata = {attr, CHAR_SPACE};
        mem_req.raddr = ptr_reg;
        case (state_reg)
            ST_DISPATCH: begin
                if (cmd_reg.kind == KIND_PUT && cmd_reg.char_code != CHAR_NEWLINE &&
                    cmd_reg.char_code != CHAR_BACKSPACE && is_printable) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = CELL_AW'(cursor_reg);
                    mem_req.wdata = {attr, cmd_reg.char_code};
                end
            end
            ST_BS_READ: begin
                mem_req.raddr = CELL_AW'(cursor_reg);
            end
            ST_BS_WRITE: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = CELL_AW'(cursor_reg);
                mem_req.wdata = {mem_rdata[CELL_W-1:CHAR_W], CHAR_NUL};
            end
            ST_SCRL_READ: begin
                mem_req.raddr = ptr_below;
            end
            ST_SCRL_WRITE: begin
                mem_req.we    = 1'b1;
                mem_req.wdata = mem_rdata;
            end
            ST_FILL: begin
                mem_req.we    = 1'b1;
            end
            ST_RCLR_WRITE: begin
                mem_req.we    = 1'b1;
                mem_req.wdata = {attr, mem_rdata[CHAR_W-1:0]};
            end
            ST_CELL_READ: begin
                mem_req.raddr = CELL_AW'(cmd_reg.cell_index);
            end
            default: begin
                mem_req.we    = 1'b0;
            end
        endcase
    end

    // Datapath registers.
    always_comb begin
        cmd_next     = cmd_reg;
        ptr_next     = ptr_reg;
        cursor_next  = cursor_reg;
        col_next     = col_reg;
        rd_char_next = rd_char_reg;
        rd_attr_next = rd_attr_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    cmd_next = cmd;
                end
            end
            ST_DISPATCH: begin
                rd_char_next = '0;
                rd_attr_next = '0;
                ptr_next     = '0;
                case (cmd_reg.kind)
                    KIND_PUT: begin
                        if (cmd_reg.char_code == CHAR_NEWLINE) begin
                            col_next    = '0;
                            cursor_next = (cur_newline == CUR_W'(CELLS)) ?
                                          CUR_W'(CELLS - COLUMNS) : cur_newline;
                        end else if (cmd_reg.char_code == CHAR_BACKSPACE) begin
                            if (cursor_reg != '0) begin
                                cursor_next = cursor_reg - CUR_W'(1);
                                col_next    = col_dec;
                            end
                        end else if (is_printable) begin
                            if (cur_inc == CUR_W'(CELLS)) begin
                                cursor_next = CUR_W'(CELLS - COLUMNS);
                                col_next    = '0;
                            end else begin
                                cursor_next = cur_inc;
                                col_next    = col_inc;
                            end
                        end
                    end
                    KIND_CLEAR: begin
                        cursor_next = '0;
                        col_next    = '0;
                    end
                    default: begin
                        cursor_next = cursor_reg;
                    end
                endcase
            end
            ST_SCRL_WRITE: begin
                ptr_next = ptr_is_scroll_last ? CELL_AW'(CELLS - COLUMNS) : ptr_inc;
            end
            ST_FILL, ST_RCLR_WRITE: begin
                ptr_next = ptr_inc;
            end
            ST_CELL_TAKE: begin
                rd_char_next = mem_rdata[CHAR_W-1:0];
                rd_attr_next = mem_rdata[CELL_W-1:CHAR_W];
            end
            default: begin
                ptr_next = ptr_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cursor_reg <= '0;
            col_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            col_reg    <= col_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        ptr_reg     <= ptr_next;
        rd_char_reg <= rd_char_next;
        rd_attr_reg <= rd_attr_next;
    end

    assign status.idle        = (state_reg == ST_IDLE);
    assign status.done        = (state_reg == ST_DONE);
    assign status.cursor_cell = INDEX_W'(cursor_reg);
    assign status.cell_char   = rd_char_reg;
    assign status.cell_attr   = rd_attr_reg;

    `TCW_ASSERT_ALWAYS(a_cursor_range, 32'(cursor_reg) < CELLS, "cursor beyond the screen")
    `TCW_ASSERT_ALWAYS(a_col_range, 32'(col_reg) < COLUMNS, "column beyond the row")
    `TCW_ASSERT_IMPLIES(a_write_busy, mem_req.we, state_reg != ST_IDLE && state_reg != ST_DONE, "store written while not working")
    `TCW_ASSERT_NEXT(a_done_release, state_reg == ST_DONE && out_free, state_reg == ST_IDLE, "result not released")

endmodule

`default_nettype wire

// ----- hw/rtl/text_console_writer_top.sv -----
`default_nettype none

// Text console writer. Items arrive on the s_ channel (valid/ready) and each
// yields exactly one result item on the m_ channel (valid/ready), in order.
// A put item writes a printable byte (0x20 to 0x7F) with the current
// attribute, handles newline and backspace, and ignores other bytes; the
// other kinds clear the screen, read one cell or recolour every cell.
// The user must write the attribute register via cfg_wr_en/cfg_wr_data while
// the block is idle (not enforced by the block); it applies from the next item.
// An accepted item goes from IDLE to DISPATCH; a put that stores, moves or
// ignores without scrolling and a read past the last cell then go to DONE,
// a backspace through BS_READ and BS_WRITE, an in-range cell read through
// CELL_READ and CELL_TAKE. A scroll reads and writes each cell of the rows
// that move up, then fills the last row; a clear fills every cell and a
// recolour reads and writes every cell, all set by the single port pair of
// the cell store. One item is worked on at a time; s_ready rises at the
// edge that loads the result into the output register.
// A stalled receiver holds the result in the output register; the sequencer
// waits in its final state until that register is free.
// Reset clears the cursor to cell 0 and the attribute to 0x17. The cell
// store is not cleared: issue a clear item before reading cells.
module text_console_writer_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [tcw_pkg::ATTR_W-1:0]     cfg_wr_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [tcw_pkg::KIND_W-1:0]     s_kind,
    input  wire logic [tcw_pkg::CHAR_W-1:0]     s_char_code,
    input  wire logic [tcw_pkg::INDEX_W-1:0]    s_cell_index,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [tcw_pkg::INDEX_W-1:0]         m_cursor_cell,
    output logic [tcw_pkg::CHAR_W-1:0]          m_cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]          m_cell_attr
);

    import tcw_pkg::*;

    logic [ATTR_W-1:0]   attr_reg;
    logic                m_valid_reg;
    logic [INDEX_W-1:0]  m_cursor_reg;
    logic [CHAR_W-1:0]   m_char_reg;
    logic [ATTR_W-1:0]   m_attr_reg;

    cmd_t                cmd;
    mem_req_t            mem_req;
    seq_status_t         status;
    logic [CELL_W-1:0]   mem_rdata;
    logic                start;
    logic                out_free;
    logic                load_out;

    // The input item is taken whenever the sequencer is idle.
    assign s_ready  = status.idle;
    assign start    = s_valid && s_ready;
    assign cmd      = '{kind: kind_t'(s_kind), char_code: s_char_code,
                        cell_index: s_cell_index};

    // The output register is free when empty or being emptied this cycle.
    assign out_free = !m_valid_reg || m_ready;
    assign load_out = status.done && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= ATTR_RESET;
        end else if (cfg_wr_en) begin
            attr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_cursor_reg <= status.cursor_cell;
            m_char_reg   <= status.cell_char;
            m_attr_reg   <= status.cell_attr;
        end
    end

    tcw_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .cmd       (cmd),
        .attr      (attr_reg),
        .out_free  (out_free),
        .mem_rdata (mem_rdata),
        .mem_req   (mem_req),
        .status    (status)
    );

    tcw_cell_ram #(
        .DEPTH (CELLS),
        .WIDTH (CELL_W),
        .AW    (CELL_AW)
    ) u_cell_ram (
        .aclk  (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    assign m_valid       = m_valid_reg;
    assign m_cursor_cell = m_cursor_reg;
    assign m_cell_char   = m_char_reg;
    assign m_cell_attr   = m_attr_reg;

endmodule

`default_nettype wire
